// File: rtl/core/e2c_pkg.sv
// shared constants for the energy to channel inverse block
package e2c_pkg;

  localparam int unsigned DATA_W           = 48;
  localparam int unsigned COUNT_W          = 17;
  localparam int unsigned CFG_IDX_W        = 3;
  localparam int unsigned COEF_NUM         = 5;
  localparam int unsigned CHANNEL_BITS_DEF = 16;
  localparam int unsigned MAX_ORDER_DEF    = 4;

  // serial multiplier: operand magnitudes up to 49 bits
  localparam int unsigned MUL_BITS = 49;
  // divider operand widths
  localparam int unsigned NUM_W    = 53;
  localparam int unsigned DEN_W    = 50;
  // square root radicand and root widths
  localparam int unsigned SQ_W     = 100;
  localparam int unsigned ROOT_W   = SQ_W / 2;
  localparam int unsigned REM_W    = ROOT_W + 3;

  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_POLY   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_DEGEN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF3 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COEF4 = 3'd7;

endpackage

// File: rtl/core/energy_to_channel_inverse.sv
// energy to channel inverse calibration: top level, sequencer and shared datapath
//
// One item is taken when start is high and busy is low; busy stays high until the
// result is produced, then done_o pulses for exactly one cycle with channel_o and
// status_o, and the receiver cannot stall it. Mode none, a zero slope and a zero
// quadratic term finish straight from idle. Linear mode runs the bit-serial divider.
// Quadratic mode runs two serial multiplies, a bit-pair square root and the
// divider, ending early with a range status on a negative discriminant. Other
// polynomial orders run a binary search of ceil(log2(channel_count)) steps, each
// a Horner evaluation on the shared shift-add multiplier.
module energy_to_channel_inverse #(
  parameter int unsigned CHANNEL_BITS = e2c_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned MAX_ORDER    = e2c_pkg::MAX_ORDER_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [e2c_pkg::DATA_W-1:0]  energy_i,
  input  logic                               cfg_we_i,
  input  logic [e2c_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [e2c_pkg::DATA_W-1:0]         cfg_wdata_i,
  output logic                               done_o,
  output logic [CHANNEL_BITS-1:0]            channel_o,
  output logic [1:0]                         status_o
);
  import e2c_pkg::*;

  localparam int unsigned CW     = CHANNEL_BITS + 1;
  localparam int unsigned EXT_W  = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int unsigned POLY_W = MAX_ORDER * CHANNEL_BITS + 52;
  localparam int unsigned ACC_W  = (POLY_W > SQ_W) ? POLY_W : SQ_W;
  localparam int unsigned MCNT_W = $clog2(MUL_BITS + 2);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_QMUL1, S_QMUL2, S_QDISC, S_SQRT, S_QPREP,
    S_BS_CHECK, S_BS_NEXT, S_BS_MUL, S_BS_ADD
  } state_e;

  // configuration
  logic [1:0]                 mode_q;
  logic [2:0]                 order_q;
  logic [COUNT_W-1:0]         count_q;
  logic signed [DATA_W-1:0]   coef_q [COEF_NUM];

  state_e                     state_q;
  logic signed [DATA_W-1:0]   e_q;
  logic signed [ACC_W-1:0]    tmp_q;
  logic signed [ACC_W-1:0]    prod_q;
  logic signed [ACC_W-1:0]    mc_q;
  logic [MUL_BITS-1:0]        m_q;
  logic [MCNT_W-1:0]          mcnt_q;
  logic                       neg_q;
  logic [CW-1:0]              lo_q;
  logic [CW-1:0]              hi_q;
  logic [CHANNEL_BITS-1:0]    mi_q;
  logic [2:0]                 k_q;
  logic [SQ_W-1:0]            rad_q;
  logic [ROOT_W-1:0]          root_q;
  logic [REM_W-1:0]           rem_q;
  logic                       div_go_q;
  logic signed [NUM_W-1:0]    div_num_q;
  logic signed [DEN_W-1:0]    div_den_q;
  logic                       done_q;
  logic [CHANNEL_BITS-1:0]    chan_q;
  logic [1:0]                 stat_q;

  logic                       div_done;
  logic signed [NUM_W:0]      div_quot;

  logic [2:0]                 ord_eff;
  logic [EXT_W-1:0]           cnt_ext;
  logic [EXT_W-1:0]           lim_ext;
  logic [CW-1:0]              cnt_eff;
  logic signed [ACC_W-1:0]    prod_nx;
  logic signed [ACC_W-1:0]    disc;
  logic signed [ACC_W-1:0]    e_ext;
  logic signed [MUL_BITS-1:0] b_ext;
  logic [MUL_BITS-1:0]        abs_b;
  logic signed [MUL_BITS-1:0] diff;
  logic [MUL_BITS-1:0]        abs_diff;
  logic [REM_W-1:0]           rem_sh;
  logic [REM_W-1:0]           trial;
  logic                       sq_ge;
  logic [CW:0]                lo_p1;
  logic [CW:0]                mid_sum;
  logic signed [NUM_W-1:0]    root_s;
  logic signed [NUM_W-1:0]    b_num;
  logic signed [DEN_W-1:0]    c2_2;
  logic                       c2_pos;
  logic                       in_range;

  assign ord_eff = (order_q > 3'(MAX_ORDER)) ? 3'(MAX_ORDER) : order_q;
  assign cnt_ext = EXT_W'(count_q);
  assign lim_ext = EXT_W'(1) << CHANNEL_BITS;
  assign cnt_eff = (cnt_ext > lim_ext) ? lim_ext[CW-1:0] : cnt_ext[CW-1:0];

  // shift-add step, multiplier bits taken msb first
  assign prod_nx = (prod_q <<< 1) + (m_q[MUL_BITS-1] ? mc_q : '0);
  assign disc    = neg_q ? (tmp_q + (prod_q <<< 2)) : (tmp_q - (prod_q <<< 2));
  assign e_ext   = ACC_W'(e_q);

  assign b_ext    = MUL_BITS'(coef_q[1]);
  assign abs_b    = b_ext[MUL_BITS-1] ? MUL_BITS'(-b_ext) : MUL_BITS'(b_ext);
  assign diff     = MUL_BITS'(coef_q[0]) - MUL_BITS'(e_q);
  assign abs_diff = diff[MUL_BITS-1] ? MUL_BITS'(-diff) : MUL_BITS'(diff);

  // bit-pair square root step
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[SQ_W-1 -: 2]};
  assign trial  = REM_W'({root_q, 2'b01});
  assign sq_ge  = rem_sh >= trial;

  assign lo_p1   = {1'b0, lo_q} + 1'b1;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};

  assign root_s = $signed(NUM_W'(root_q));
  assign b_num  = NUM_W'(coef_q[1]);
  assign c2_2   = DEN_W'(coef_q[2]) <<< 1;
  assign c2_pos = !coef_q[2][DATA_W-1] && (coef_q[2] != '0);

  assign in_range = !div_quot[NUM_W] && (div_quot[NUM_W-1:0] < NUM_W'(cnt_eff));

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      order_q <= 3'd1;
      count_q <= COUNT_W'(65536);
      for (int i = 0; i < COEF_NUM; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:  mode_q    <= cfg_wdata_i[1:0];
        REG_ORDER: order_q   <= cfg_wdata_i[2:0];
        REG_COUNT: count_q   <= cfg_wdata_i[COUNT_W-1:0];
        REG_COEF0: coef_q[0] <= cfg_wdata_i;
        REG_COEF1: coef_q[1] <= cfg_wdata_i;
        REG_COEF2: coef_q[2] <= cfg_wdata_i;
        REG_COEF3: coef_q[3] <= cfg_wdata_i;
        REG_COEF4: coef_q[4] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      div_go_q <= 1'b0;
      stat_q   <= ST_OK;
      chan_q   <= '0;
    end else begin
      done_q   <= 1'b0;
      div_go_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            e_q <= energy_i;
            if (mode_q == MODE_LINEAR) begin
              if (coef_q[1] == '0) begin
                done_q <= 1'b1;
                chan_q <= '0;
                stat_q <= ST_DEGEN;
              end else begin
                div_num_q <= NUM_W'(energy_i) - NUM_W'(coef_q[0]);
                div_den_q <= DEN_W'(coef_q[1]);
                div_go_q  <= 1'b1;
                state_q   <= S_DIV;
              end
            end else if (mode_q == MODE_POLY && ord_eff == 3'd2) begin
              if (coef_q[2] == '0) begin
                done_q <= 1'b1;
                chan_q <= '0;
                stat_q <= ST_DEGEN;
              end else begin
                mc_q    <= $signed(ACC_W'(abs_b));
                m_q     <= abs_b;
                prod_q  <= '0;
                mcnt_q  <= MCNT_W'(MUL_BITS);
                state_q <= S_QMUL1;
              end
            end else if (mode_q == MODE_POLY) begin
              lo_q    <= '0;
              hi_q    <= cnt_eff;
              state_q <= S_BS_CHECK;
            end else begin
              done_q <= 1'b1;
              chan_q <= '0;
              stat_q <= ST_OK;
            end
          end
        end
        S_QMUL1: begin
          prod_q <= prod_nx;
          m_q    <= m_q << 1;
          mcnt_q <= mcnt_q - 1'b1;
          if (mcnt_q == MCNT_W'(1)) begin
            tmp_q   <= prod_nx;
            mc_q    <= ACC_W'(coef_q[2]);
            m_q     <= abs_diff;
            neg_q   <= diff[MUL_BITS-1];
            prod_q  <= '0;
            mcnt_q  <= MCNT_W'(MUL_BITS);
            state_q <= S_QMUL2;
          end
        end
        S_QMUL2: begin
          prod_q <= prod_nx;
          m_q    <= m_q << 1;
          mcnt_q <= mcnt_q - 1'b1;
          if (mcnt_q == MCNT_W'(1)) begin
            state_q <= S_QDISC;
          end
        end
        S_QDISC: begin
          if (disc[ACC_W-1]) begin
            done_q  <= 1'b1;
            chan_q  <= '0;
            stat_q  <= ST_RANGE;
            state_q <= S_IDLE;
          end else begin
            rad_q   <= disc[SQ_W-1:0];
            root_q  <= '0;
            rem_q   <= '0;
            mcnt_q  <= MCNT_W'(ROOT_W);
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          rad_q  <= rad_q << 2;
          root_q <= {root_q[ROOT_W-2:0], sq_ge};
          rem_q  <= sq_ge ? (rem_sh - trial) : rem_sh;
          mcnt_q <= mcnt_q - 1'b1;
          if (mcnt_q == MCNT_W'(1)) begin
            state_q <= S_QPREP;
          end
        end
        S_QPREP: begin
          // floor of the root over 2c, rounding toward the smaller channel
          if (c2_pos) begin
            div_num_q <= root_s - b_num;
            div_den_q <= c2_2;
          end else begin
            div_num_q <= b_num - root_s - NUM_W'(rem_q != '0);
            div_den_q <= -c2_2;
          end
          div_go_q <= 1'b1;
          state_q  <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            done_q  <= 1'b1;
            chan_q  <= in_range ? div_quot[CHANNEL_BITS-1:0] : '0;
            stat_q  <= in_range ? ST_OK : ST_RANGE;
            state_q <= S_IDLE;
          end
        end
        S_BS_CHECK: begin
          if ({1'b0, hi_q} > lo_p1) begin
            mi_q    <= mid_sum[CHANNEL_BITS:1];
            tmp_q   <= ACC_W'(coef_q[ord_eff]);
            k_q     <= ord_eff;
            state_q <= S_BS_NEXT;
          end else begin
            done_q  <= 1'b1;
            chan_q  <= lo_q[CHANNEL_BITS-1:0];
            stat_q  <= ST_OK;
            state_q <= S_IDLE;
          end
        end
        S_BS_NEXT: begin
          if (k_q == '0) begin
            if (e_ext >= tmp_q) begin
              lo_q <= CW'(mi_q);
            end else begin
              hi_q <= CW'(mi_q);
            end
            state_q <= S_BS_CHECK;
          end else begin
            mc_q    <= tmp_q;
            m_q     <= MUL_BITS'(mi_q) << (MUL_BITS - CHANNEL_BITS);
            prod_q  <= '0;
            mcnt_q  <= MCNT_W'(CHANNEL_BITS);
            k_q     <= k_q - 1'b1;
            state_q <= S_BS_MUL;
          end
        end
        S_BS_MUL: begin
          prod_q <= prod_nx;
          m_q    <= m_q << 1;
          mcnt_q <= mcnt_q - 1'b1;
          if (mcnt_q == MCNT_W'(1)) begin
            state_q <= S_BS_ADD;
          end
        end
        S_BS_ADD: begin
          tmp_q   <= prod_q + ACC_W'(coef_q[k_q]);
          state_q <= S_BS_NEXT;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  e2c_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .num_i   (div_num_q),
    .den_i   (div_den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign busy      = (state_q != S_IDLE);
  assign done_o    = done_q;
  assign channel_o = chan_q;
  assign status_o  = stat_q;

endmodule

// File: rtl/core/e2c_div.sv
// restoring signed divider with floor rounding, one quotient bit per cycle
module e2c_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [e2c_pkg::NUM_W-1:0] num_i,
  input  logic signed [e2c_pkg::DEN_W-1:0] den_i,
  output logic                           done_o,
  output logic signed [e2c_pkg::NUM_W:0]   quot_o
);
  import e2c_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} div_state_e;

  div_state_e         state_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [NUM_W-1:0]   q_q;
  logic [DEN_W-1:0]   rem_q;
  logic [DEN_W-1:0]   dmag_q;
  logic               neg_q;
  logic               done_q;
  logic signed [NUM_W:0] quot_q;

  logic [NUM_W-1:0]   nmag;
  logic [DEN_W-1:0]   dmag;
  logic [DEN_W:0]     rem_sh;
  logic               ge;
  logic [DEN_W:0]     rem_sub;
  logic [DEN_W-1:0]   rem_nx;
  logic signed [NUM_W:0] q_ext;

  assign nmag    = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
  assign dmag    = den_i[DEN_W-1] ? DEN_W'(-den_i) : DEN_W'(den_i);
  assign rem_sh  = {rem_q, q_q[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, dmag_q};
  assign rem_sub = rem_sh - {1'b0, dmag_q};
  assign rem_nx  = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  assign q_ext   = $signed({1'b0, q_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            q_q     <= nmag;
            dmag_q  <= dmag;
            rem_q   <= '0;
            neg_q   <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
            cnt_q   <= CNT_W'(NUM_W);
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          // quotient bits shift in where the dividend bits leave
          rem_q <= rem_nx;
          q_q   <= {q_q[NUM_W-2:0], ge};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CNT_W'(1)) begin
            state_q <= D_FIX;
          end
        end
        D_FIX: begin
          if (neg_q) begin
            quot_q <= -q_ext - (NUM_W+1)'(rem_q != '0);
          end else begin
            quot_q <= q_ext;
          end
          done_q  <= 1'b1;
          state_q <= D_IDLE;
        end
        default: begin
          state_q <= D_IDLE;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: rtl/core/e2c_checker.sv
// port-level checks for the energy to channel inverse block, bound to the top level
module e2c_checker #(
  parameter int unsigned CHANNEL_BITS = e2c_pkg::CHANNEL_BITS_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic                    done_o,
  input logic [CHANNEL_BITS-1:0] channel_o,
  input logic [1:0]              status_o
);
  import e2c_pkg::*;

  // an accepted item either finishes at once or keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("item accepted but neither busy nor done");

  // the block only goes idle by delivering a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  // a result is only shown once the block is ready again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // a failed item always reports channel zero with a legal code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |->
      (channel_o == '0 && (status_o == ST_RANGE || status_o == ST_DEGEN)))
    else $error("bad failure result");

endmodule

bind energy_to_channel_inverse e2c_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_e2c_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .done_o    (done_o),
  .channel_o (channel_o),
  .status_o  (status_o)
);
